### rtl/repeated_symbol_combiner_assert.svh
// Assertion macros shared by the combiner RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef REPEATED_SYMBOL_COMBINER_ASSERT_SVH
`define REPEATED_SYMBOL_COMBINER_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define RSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsc assertion failed");
// condition that must never be seen out of reset
`define RSC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rsc forbidden condition seen");
`else
`define RSC_ASSERT(lbl, prop)
`define RSC_NEVER(lbl, cond)
`endif
`endif

### rtl/rsc_pkg.sv
// Shared constants and types for the repeated symbol combiner.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rsc_pkg;
	localparam int NUM_SYMBOLS = 108;
	localparam int SAMPLE_W    = 16;
	localparam int ACC_W       = SAMPLE_W + 3;   // room for eight repeats
	localparam int IDX_W       = 7;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;
	localparam int CFG_W       = 2;

	// register indexes on the configuration port
	localparam logic REG_TRANS_MODE  = 1'b0;
	localparam logic REG_DOUBLE_BAND = 1'b1;

	// transmission mode with two lanes and 54 groups
	localparam logic [1:0] MODE_2 = 2'd1;

	localparam logic [5:0] GROUPS_NARROW = 6'd54;
	localparam logic [5:0] GROUPS_WIDE   = 6'd27;

	// one classified sample, front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic [IDX_W-1:0]           idx;
		logic                       first;   // overwrite instead of add
		logic                       emit;    // last repeat, produce average
		logic                       shift3;  // eight repeats
		logic                       last;    // final symbol of subframe
	} rsc_item_t;
endpackage

### rtl/rsc_front.sv
// Front end: configuration registers, subframe position counters, classification.
// Depends on rsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "repeated_symbol_combiner_assert.svh"
module rsc_front import rsc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       push,
	input  logic signed [SAMPLE_W-1:0] sample_re,
	input  logic signed [SAMPLE_W-1:0] sample_im,
	input  logic                       frame_start,
	input  logic                       q_full,
	output logic                       enq,
	output rsc_item_t                  enq_item
);
	logic [1:0] trans_mode_q;
	logic       double_band_q;
	logic [1:0] lane_q, slot_q;
	logic [5:0] group_q;
	logic       half_q;

	logic       accept;
	logic [1:0] lane_c, slot_c, lane_n, slot_n;
	logic [5:0] group_c, group_n, groups;
	logic       half_c, mode2, in_range, lane_wrap, slot_wrap, group_wrap;
	logic [7:0] idx_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_mode_q  <= '0;
			double_band_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANS_MODE:  trans_mode_q  <= cfg_data;
				REG_DOUBLE_BAND: double_band_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept = push && !q_full;
	assign mode2  = (trans_mode_q == MODE_2);
	assign groups = mode2 ? GROUPS_NARROW : GROUPS_WIDE;

	// position of this beat, frame start resyncs to zero
	assign lane_c  = frame_start ? 2'd0 : lane_q;
	assign slot_c  = frame_start ? 2'd0 : slot_q;
	assign group_c = frame_start ? 6'd0 : group_q;
	assign half_c  = frame_start ? 1'b0 : half_q;

	// symbol index = group * lanes + lane
	assign idx_w = (mode2 ? {1'b0, group_c, 1'b0} : {group_c, 2'b00}) + {6'd0, lane_c};
	assign in_range = (!mode2 || lane_c < 2'd2) && (double_band_q || slot_c < 2'd2) &&
		(group_c < groups) && (idx_w < 8'(NUM_SYMBOLS));

	always_comb begin
		enq_item.re     = sample_re;
		enq_item.im     = sample_im;
		enq_item.idx    = idx_w[IDX_W-1:0];
		enq_item.first  = !half_c && (slot_c == 2'd0);
		enq_item.emit   = half_c && (slot_c == (double_band_q ? 2'd3 : 2'd1));
		enq_item.shift3 = double_band_q;
		enq_item.last   = (idx_w == 8'(NUM_SYMBOLS - 1));
	end
	assign enq = accept && in_range;

	// counter advance: lane, slot, group, half
	assign lane_n     = lane_c + 2'd1;
	assign lane_wrap  = (lane_n == 2'd0) || (mode2 && lane_n >= 2'd2);
	assign slot_n     = slot_c + 2'd1;
	assign slot_wrap  = (slot_n == 2'd0) || (!double_band_q && slot_n >= 2'd2);
	assign group_n    = group_c + 6'd1;
	assign group_wrap = (group_n == 6'd0) || (group_n >= groups);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q  <= '0;
			slot_q  <= '0;
			group_q <= '0;
			half_q  <= 1'b0;
		end else if (accept) begin
			lane_q  <= lane_wrap ? 2'd0 : lane_n;
			slot_q  <= !lane_wrap ? slot_c : (slot_wrap ? 2'd0 : slot_n);
			group_q <= !(lane_wrap && slot_wrap) ? group_c : (group_wrap ? 6'd0 : group_n);
			half_q  <= (lane_wrap && slot_wrap && group_wrap) ? !half_c : half_c;
		end
	end

	`RSC_ASSERT(a_enq_idx_range, enq |-> (enq_item.idx < IDX_W'(NUM_SYMBOLS)))
	`RSC_ASSERT(a_frame_start_first, (accept && frame_start) |-> enq_item.first)
endmodule

### rtl/rsc_fifo.sv
// Short queue that decouples the classifier from the accumulator back end.
// Depends on rsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "repeated_symbol_combiner_assert.svh"
module rsc_fifo import rsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  rsc_item_t wr_item,
	output logic      full,
	input  logic      rd_en,
	output rsc_item_t rd_item,
	output logic      not_empty
);
	rsc_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
		end
	end

	`RSC_ASSERT(a_count_bound, count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
	`RSC_NEVER(a_read_empty, rd_en && !not_empty)
endmodule

### rtl/rsc_back.sv
// Back end: accumulator memory read-modify-write, averaging and result register.
// Depends on rsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "repeated_symbol_combiner_assert.svh"
module rsc_back import rsc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  rsc_item_t                  q_item,
	output logic                       q_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] symbol_re,
	output logic signed [SAMPLE_W-1:0] symbol_im,
	output logic [IDX_W-1:0]           symbol_index,
	output logic                       last_symbol
);
	// accumulator store: re in the upper half, im in the lower
	logic [2*ACC_W-1:0] acc_mem [NUM_SYMBOLS];

	logic                    s1_valid_q, fwd_s1;
	rsc_item_t               item_s1;
	logic [2*ACC_W-1:0]      rd_s1, wsum_q, prev;
	logic signed [ACC_W-1:0] base_re, base_im, sum_re, sum_im, avg_re, avg_im;
	logic                    s1_done, out_valid_q;

	// stage 1 retires unless its result would overrun a held output
	assign s1_done = s1_valid_q && !(item_s1.emit && out_valid_q && !pop);
	assign q_pop   = q_not_empty && (!s1_valid_q || s1_done);

	// memory read on take; write of the retiring beat at the same edge
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= acc_mem[q_item.idx];
		end
	end
	always_ff @(posedge clk) begin
		if (s1_done) begin
			acc_mem[item_s1.idx] <= {sum_re, sum_im};
		end
	end

	// stage 1 payload and bypass of a same-edge write
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			fwd_s1  <= s1_done && (item_s1.idx == q_item.idx);
		end
		if (s1_done) begin
			wsum_q <= {sum_re, sum_im};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (q_pop) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	// accumulate, first repeat overwrites
	assign prev    = fwd_s1 ? wsum_q : rd_s1;
	assign base_re = item_s1.first ? '0 : $signed(prev[2*ACC_W-1:ACC_W]);
	assign base_im = item_s1.first ? '0 : $signed(prev[ACC_W-1:0]);
	assign sum_re  = base_re + ACC_W'(item_s1.re);
	assign sum_im  = base_im + ACC_W'(item_s1.im);
	// floor average over four or eight repeats
	assign avg_re  = item_s1.shift3 ? (sum_re >>> 3) : (sum_re >>> 2);
	assign avg_im  = item_s1.shift3 ? (sum_im >>> 3) : (sum_im >>> 2);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && item_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (s1_done && item_s1.emit) begin
			symbol_re    <= avg_re[SAMPLE_W-1:0];
			symbol_im    <= avg_im[SAMPLE_W-1:0];
			symbol_index <= item_s1.idx;
			last_symbol  <= item_s1.last;
		end
	end
	assign empty = !out_valid_q;

	`RSC_ASSERT(a_emit_lands, (s1_done && item_s1.emit) |=> out_valid_q)
	`RSC_NEVER(a_take_while_held, q_pop && s1_valid_q && !s1_done)
endmodule

### rtl/repeated_symbol_combiner.sv
// Top level of the repeated symbol combiner: front end, queue and back end.
// Depends on rsc_pkg, rsc_front, rsc_fifo and rsc_back.
//
//  channel   | handshake         | beat
//  ----------+-------------------+------------------------------------------
//  samples   | push / full       | sample_re, sample_im, frame_start
//  symbols   | pop / empty       | symbol_re, symbol_im, symbol_index, last_symbol
//  config    | cfg_we            | cfg_index, cfg_data
//
// One sample per cycle sustained unless a held result stalls the back end; the
// accumulator memory port does one read-modify-write per cycle with a same-edge bypass.
// A symbol's last repeat passes the queue and stage 1 before it reaches the result register.
// Reset clears counters, configuration registers and the queue; accumulators are not cleared.
// A held result stalls the back end only when it has another result ready;
// the four-entry queue then fills before full rises.
`timescale 1ns / 1ps
module repeated_symbol_combiner import rsc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample_re,
	input  logic signed [SAMPLE_W-1:0] sample_im,
	input  logic                       frame_start,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] symbol_re,
	output logic signed [SAMPLE_W-1:0] symbol_im,
	output logic [IDX_W-1:0]           symbol_index,
	output logic                       last_symbol
);
	logic      enq, q_pop, q_not_empty;
	rsc_item_t enq_item, q_item;

	rsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.frame_start (frame_start),
		.q_full      (full),
		.enq         (enq),
		.enq_item    (enq_item)
	);

	rsc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (enq),
		.wr_item   (enq_item),
		.full      (full),
		.rd_en     (q_pop),
		.rd_item   (q_item),
		.not_empty (q_not_empty)
	);

	rsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.symbol_re    (symbol_re),
		.symbol_im    (symbol_im),
		.symbol_index (symbol_index),
		.last_symbol  (last_symbol)
	);
endmodule
